// ===== rtl/bfac_pkg.sv =====
// bfac_pkg: shared constants, types and state encodings for the bloom filter block
// no dependencies; used by every module in rtl/
package bfac_pkg;

  // filter geometry
  localparam int NUM_BITS   = 20;
  localparam int NUM_HASHES = 3;

  // hash accumulator
  localparam int ACC_W         = 64;
  localparam int BYTE_W        = 8;
  localparam int ACC_INIT      = 5381;
  localparam int ACC_MUL_SHIFT = 5;   // h*33 = (h << 5) + h

  // remainder unit: RADIX bits of the dividend per cycle
  localparam int RADIX     = 4;
  localparam int DIV_STEPS = ACC_W / RADIX;
  localparam int STEP_W    = $clog2(DIV_STEPS);
  localparam int REM_W     = $clog2(NUM_BITS);
  localparam int HIDX_W    = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;

  localparam logic [REM_W:0] NUM_BITS_CMP = (REM_W + 1)'(NUM_BITS);

  // front-to-back queue, depth is a power of two
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);

  // mode codes
  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_CHECK = 1'b1;

  typedef logic [NUM_HASHES-1:0][ACC_W-1:0] acc_vec_t;

  typedef struct packed {
    logic     mode;
    acc_vec_t acc;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [0:0] {
    FR_IDLE,
    FR_SCALE
  } front_state_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_DIV,
    BK_MEM,
    BK_CHK,
    BK_OUT
  } back_state_t;

endpackage

// ===== rtl/bloom_filter_add_check.sv =====
// bloom_filter_add_check: top level of the byte-string bloom filter
// depends on bfac_pkg, bfac_front, bfac_queue, bfac_back
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------
//   input    | in        | push / full        | in_mode, in_byte_value
//   result   | out       | empty / pop        | out_present, out_was_check
//
// a nonzero byte goes through the front as h*33+c, then times the seed
// a terminator lands in the 2-deep string queue
// the back handles one string at a time, its hashes in turn through the shared
//   remainder unit at RADIX dividend bits per cycle
// after reset a clearing pass over all NUM_BITS filter bits keeps full high
// a waiting result does not stall the front until the string queue fills
module bloom_filter_add_check (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_mode,
  input  logic [bfac_pkg::BYTE_W-1:0]  in_byte_value,
  output logic                         empty,
  input  logic                         pop,
  output logic                         out_present,
  output logic                         out_was_check
);

  // front to queue
  logic               q_push;
  bfac_pkg::q_entry_t q_entry;
  // queue to back
  bfac_pkg::q_entry_t q_head;
  bfac_pkg::q_stat_t  q_stat;
  logic               q_pop;
  // back status: filter memory sweep in progress
  logic               clearing;
  logic               out_valid;

  bfac_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_mode       (in_mode),
    .in_byte_value (in_byte_value),
    .q_stat        (q_stat),
    .clearing      (clearing),
    .q_push        (q_push),
    .q_entry       (q_entry)
  );

  // decouples string intake from the slow per-string back end
  bfac_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (q_push),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .q_stat  (q_stat)
  );

  // remainder unit, filter memory and the result register
  bfac_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_head        (q_head),
    .q_stat        (q_stat),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .out_pop       (pop),
    .out_valid     (out_valid),
    .out_present   (out_present),
    .out_was_check (out_was_check)
  );

  // result side looks like a queue: empty while no item waits
  assign empty = !out_valid;

endmodule

// ===== rtl/bfac_front.sv =====
// bfac_front: byte intake and hash accumulators, hands finished strings to the queue
// depends on bfac_pkg
module bfac_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic                         in_mode,
  input  logic [bfac_pkg::BYTE_W-1:0]  in_byte_value,
  input  bfac_pkg::q_stat_t            q_stat,
  input  logic                         clearing,
  output logic                         q_push,
  output bfac_pkg::q_entry_t           q_entry
);

  bfac_pkg::front_state_t state_r, state_nxt;
  bfac_pkg::acc_vec_t     acc_r, acc_nxt;
  bfac_pkg::acc_vec_t     t_r, t_nxt;
  logic                   accept;
  logic                   is_term;

  assign full    = (state_r != bfac_pkg::FR_IDLE) || q_stat.full || clearing;
  assign accept  = push && !full;
  assign is_term = (in_byte_value == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfac_pkg::FR_IDLE: begin
        if (accept && !is_term) state_nxt = bfac_pkg::FR_SCALE;
      end
      bfac_pkg::FR_SCALE: begin
        state_nxt = bfac_pkg::FR_IDLE;
      end
      default: state_nxt = bfac_pkg::FR_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_push        = 1'b0;
    q_entry.mode  = in_mode;
    q_entry.acc   = acc_r;
    case (state_r)
      bfac_pkg::FR_IDLE:  q_push = accept && is_term;
      bfac_pkg::FR_SCALE: q_push = 1'b0;
      default:            q_push = 1'b0;
    endcase
  end

  // accumulator datapath: h*33 + c on accept, then times the seed; a terminator reloads ACC_INIT
  always_comb begin
    acc_nxt = acc_r;
    t_nxt   = t_r;
    for (int s = 0; s < bfac_pkg::NUM_HASHES; s++) begin
      t_nxt[s] = (acc_r[s] << bfac_pkg::ACC_MUL_SHIFT) + acc_r[s]
               + bfac_pkg::ACC_W'(in_byte_value);
    end
    if (state_r == bfac_pkg::FR_SCALE) begin
      for (int s = 0; s < bfac_pkg::NUM_HASHES; s++) begin
        acc_nxt[s] = t_r[s] * bfac_pkg::ACC_W'(s + 1);
      end
    end else if (accept && is_term) begin
      for (int s = 0; s < bfac_pkg::NUM_HASHES; s++) begin
        acc_nxt[s] = bfac_pkg::ACC_W'(bfac_pkg::ACC_INIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bfac_pkg::FR_IDLE;
      for (int s = 0; s < bfac_pkg::NUM_HASHES; s++) begin
        acc_r[s] <= bfac_pkg::ACC_W'(bfac_pkg::ACC_INIT);
      end
    end else begin
      state_r <= state_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt;
  end

endmodule

// ===== rtl/bfac_queue.sv =====
// bfac_queue: short fifo of finished strings between front and back
// depends on bfac_pkg
module bfac_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_push,
  input  bfac_pkg::q_entry_t q_entry,
  input  logic               q_pop,
  output bfac_pkg::q_entry_t q_head,
  output bfac_pkg::q_stat_t  q_stat
);

  bfac_pkg::q_entry_t             slot_r [bfac_pkg::QDEPTH];
  logic [bfac_pkg::QPTR_W-1:0]    wp_r, wp_nxt;
  logic [bfac_pkg::QPTR_W-1:0]    rp_r, rp_nxt;
  logic [bfac_pkg::QPTR_W:0]      cnt_r, cnt_nxt;

  assign q_stat.full  = (cnt_r == (bfac_pkg::QPTR_W + 1)'(bfac_pkg::QDEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign q_head       = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (q_push) wp_nxt = wp_r + 1'b1;
    if (q_pop)  rp_nxt = rp_r + 1'b1;
    case ({q_push, q_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) slot_r[wp_r] <= q_entry;
  end

endmodule

// ===== rtl/bfac_back.sv =====
// bfac_back: per-string remainder unit, filter bit memory and result register
// depends on bfac_pkg
module bfac_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bfac_pkg::q_entry_t q_head,
  input  bfac_pkg::q_stat_t  q_stat,
  output logic               q_pop,
  output logic               clearing,
  input  logic               out_pop,
  output logic               out_valid,
  output logic               out_present,
  output logic               out_was_check
);

  bfac_pkg::back_state_t          state_r, state_nxt;
  logic [bfac_pkg::REM_W-1:0]     clr_r, clr_nxt;
  logic [bfac_pkg::HIDX_W-1:0]    hidx_r, hidx_nxt, hidx_inc;
  logic [bfac_pkg::STEP_W-1:0]    step_r, step_nxt;
  logic [bfac_pkg::REM_W-1:0]     rem_r, rem_nxt, rem_div;
  logic [bfac_pkg::ACC_W-1:0]     sh_r, sh_nxt;
  bfac_pkg::acc_vec_t             accs_r, accs_nxt;
  logic                           mode_r, mode_nxt;
  logic                           allset_r, allset_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           out_present_r, out_present_nxt;
  logic                           out_was_check_r, out_was_check_nxt;
  logic                           clr_last, step_last, hash_last;
  logic                           mem_we, mem_wd;
  logic [bfac_pkg::REM_W-1:0]     mem_wa;
  logic                           rd_r;
  logic                           filter_mem [bfac_pkg::NUM_BITS];

  assign clr_last  = (clr_r == bfac_pkg::REM_W'(bfac_pkg::NUM_BITS - 1));
  assign step_last = (step_r == bfac_pkg::STEP_W'(bfac_pkg::DIV_STEPS - 1));
  assign hash_last = (hidx_r == bfac_pkg::HIDX_W'(bfac_pkg::NUM_HASHES - 1));
  assign hidx_inc  = hidx_r + 1'b1;

  assign out_valid     = out_valid_r;
  assign out_present   = out_present_r;
  assign out_was_check = out_was_check_r;

  // RADIX restoring remainder steps, msb first
  always_comb begin
    logic [bfac_pkg::REM_W:0]   w;
    logic [bfac_pkg::REM_W-1:0] r;
    r = rem_r;
    w = '0;
    for (int i = 0; i < bfac_pkg::RADIX; i++) begin
      w = {r, sh_r[bfac_pkg::ACC_W-1-i]};
      if (w >= bfac_pkg::NUM_BITS_CMP) w = w - bfac_pkg::NUM_BITS_CMP;
      r = w[bfac_pkg::REM_W-1:0];
    end
    rem_div = r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bfac_pkg::BK_CLEAR: if (clr_last) state_nxt = bfac_pkg::BK_IDLE;
      bfac_pkg::BK_IDLE:  if (!q_stat.empty) state_nxt = bfac_pkg::BK_DIV;
      bfac_pkg::BK_DIV:   if (step_last) state_nxt = bfac_pkg::BK_MEM;
      bfac_pkg::BK_MEM:   state_nxt = bfac_pkg::BK_CHK;
      bfac_pkg::BK_CHK:   state_nxt = hash_last ? bfac_pkg::BK_OUT : bfac_pkg::BK_DIV;
      bfac_pkg::BK_OUT:   if (!out_valid_r) state_nxt = bfac_pkg::BK_IDLE;
      default:            state_nxt = bfac_pkg::BK_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    q_pop    = 1'b0;
    clearing = 1'b0;
    mem_we   = 1'b0;
    mem_wa   = rem_r;
    mem_wd   = 1'b1;
    case (state_r)
      bfac_pkg::BK_CLEAR: begin
        clearing = 1'b1;
        mem_we   = 1'b1;
        mem_wa   = clr_r;
        mem_wd   = 1'b0;
      end
      bfac_pkg::BK_IDLE: q_pop  = !q_stat.empty;
      bfac_pkg::BK_MEM:  mem_we = (mode_r == bfac_pkg::MODE_ADD);
      default: begin
      end
    endcase
  end

  // datapath
  always_comb begin
    clr_nxt           = clr_r;
    hidx_nxt          = hidx_r;
    step_nxt          = step_r;
    rem_nxt           = rem_r;
    sh_nxt            = sh_r;
    accs_nxt          = accs_r;
    mode_nxt          = mode_r;
    allset_nxt        = allset_r;
    out_valid_nxt     = out_valid_r;
    out_present_nxt   = out_present_r;
    out_was_check_nxt = out_was_check_r;
    if (out_pop && out_valid_r) out_valid_nxt = 1'b0;
    case (state_r)
      bfac_pkg::BK_CLEAR: clr_nxt = clr_r + 1'b1;
      bfac_pkg::BK_IDLE: begin
        if (!q_stat.empty) begin
          accs_nxt   = q_head.acc;
          mode_nxt   = q_head.mode;
          allset_nxt = 1'b1;
          hidx_nxt   = '0;
          step_nxt   = '0;
          rem_nxt    = '0;
          sh_nxt     = q_head.acc[0];
        end
      end
      bfac_pkg::BK_DIV: begin
        rem_nxt  = rem_div;
        sh_nxt   = sh_r << bfac_pkg::RADIX;
        step_nxt = step_r + 1'b1;
      end
      bfac_pkg::BK_CHK: begin
        if (mode_r == bfac_pkg::MODE_CHECK && !rd_r) allset_nxt = 1'b0;
        if (!hash_last) begin
          hidx_nxt = hidx_inc;
          step_nxt = '0;
          rem_nxt  = '0;
          sh_nxt   = accs_r[hidx_inc];
        end
      end
      bfac_pkg::BK_OUT: begin
        if (!out_valid_r) begin
          out_valid_nxt     = 1'b1;
          out_present_nxt   = (mode_r == bfac_pkg::MODE_CHECK) && allset_r;
          out_was_check_nxt = mode_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bfac_pkg::BK_CLEAR;
      clr_r       <= '0;
      hidx_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      hidx_r      <= hidx_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r           <= rem_nxt;
    sh_r            <= sh_nxt;
    accs_r          <= accs_nxt;
    mode_r          <= mode_nxt;
    allset_r        <= allset_nxt;
    out_present_r   <= out_present_nxt;
    out_was_check_r <= out_was_check_nxt;
  end

  // filter bit memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) filter_mem[mem_wa] <= mem_wd;
    rd_r <= filter_mem[rem_r];
  end

endmodule

// ===== rtl/bfac_checker.sv =====
// bfac_checker: port-level assertions for bloom_filter_add_check, bound to the top level
// depends on bloom_filter_add_check port list and bfac_pkg
module bfac_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         push,
  input logic                         full,
  input logic                         in_mode,
  input logic [bfac_pkg::BYTE_W-1:0]  in_byte_value,
  input logic                         empty,
  input logic                         pop,
  input logic                         out_present,
  input logic                         out_was_check
);

  // reset leaves the block sweeping the filter with nothing to deliver
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (full && empty))
    else $error("full/empty wrong after reset");

  // an add never reports presence
  a_present_only_check: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (!out_present || out_was_check))
    else $error("present set on an add result");

  // a string byte keeps the front full while it is scaled
  a_byte_two_cycles: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && in_byte_value != '0) |=> full)
    else $error("front took a byte while still scaling");

  // a waiting item stays until popped
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("result dropped without pop");

endmodule

bind bloom_filter_add_check bfac_checker u_bfac_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .push          (push),
  .full          (full),
  .in_mode       (in_mode),
  .in_byte_value (in_byte_value),
  .empty         (empty),
  .pop           (pop),
  .out_present   (out_present),
  .out_was_check (out_was_check)
);
